/* rtl/core/ising2d_pkg.sv */
// Shared types, constants and register codes for the 2-D Ising sweep core.
package ising2d_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int RND_W      = 16;
    localparam int THR_W      = 17;
    localparam int THR_PACK_W = 3 * THR_W;
    localparam int SITE_W     = 6;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_PACK_W;
    localparam int IDX_W      = 4;

    // first table entry used by a down spin
    localparam int IDX_DOWN_BASE = 5;

    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

    // refill: one read per window row plus one lookahead read
    localparam int LOAD_CNT_W = 3;
    localparam logic [LOAD_CNT_W-1:0] LOAD_LAST = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDARY = 3'd0,
        CFG_ROWS     = 3'd1,
        CFG_COLS     = 3'd2,
        CFG_THR_A    = 3'd3,
        CFG_THR_B    = 3'd4,
        CFG_THR_C    = 3'd5,
        CFG_THR_D    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_LOAD
    } ctl_state_t;

    // one site and its four neighbours, with presence flags for free edges
    typedef struct packed {
        logic spin;
        logic up;
        logic dn;
        logic lf;
        logic rt;
        logic up_en;
        logic dn_en;
        logic lf_en;
        logic rt_en;
    } nbr_t;

endpackage

/* rtl/core/ising2d_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ising2d_ram #(
    parameter int WIDTH = ising2d_pkg::DEF_MAX_COLS,
    parameter int DEPTH = ising2d_pkg::DEF_MAX_ROWS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ising2d_site_eval.sv */
// Metropolis decision for one site: neighbour sum, table index, threshold compare.
module ising2d_site_eval (
    input  ising2d_pkg::nbr_t                     nbr,
    input  logic [ising2d_pkg::RND_W-1:0]      random_value,
    input  logic [ising2d_pkg::THR_PACK_W-1:0] thr_a,
    input  logic [ising2d_pkg::THR_PACK_W-1:0] thr_b,
    input  logic [ising2d_pkg::THR_PACK_W-1:0] thr_c,
    input  logic [ising2d_pkg::THR_W-1:0]      thr_d,
    output logic                               flip
);

    localparam int TW = ising2d_pkg::THR_W;

    logic [2:0]                       n_pos;
    logic [2:0]                       n_neg;
    logic [3:0]                       sum_ofs;   // sum + 4, 0..8
    logic [ising2d_pkg::IDX_W-1:0] idx;
    logic [TW-1:0]                    thr;

    always_comb
    begin
        n_pos = 3'(nbr.up_en & nbr.up) + 3'(nbr.dn_en & nbr.dn)
              + 3'(nbr.lf_en & nbr.lf) + 3'(nbr.rt_en & nbr.rt);
        n_neg = 3'(nbr.up_en & ~nbr.up) + 3'(nbr.dn_en & ~nbr.dn)
              + 3'(nbr.lf_en & ~nbr.lf) + 3'(nbr.rt_en & ~nbr.rt);
        sum_ofs = 4'd4 + 4'(n_pos) - 4'(n_neg);
        // floor((sum - 5*spin + 9)/2): up spin -> (sum+4)/2, down -> that plus 5
        if (nbr.spin)
        begin
            idx = {1'b0, sum_ofs[3:1]};
        end
        else
        begin
            idx = {1'b0, sum_ofs[3:1]} + 4'(ising2d_pkg::IDX_DOWN_BASE);
        end
    end

    always_comb
    begin
        case (idx)
            4'd0:    thr = thr_a[TW-1:0];
            4'd1:    thr = thr_a[2*TW-1:TW];
            4'd2:    thr = thr_a[3*TW-1:2*TW];
            4'd3:    thr = thr_b[TW-1:0];
            4'd4:    thr = thr_b[2*TW-1:TW];
            4'd5:    thr = thr_b[3*TW-1:2*TW];
            4'd6:    thr = thr_c[TW-1:0];
            4'd7:    thr = thr_c[2*TW-1:TW];
            4'd8:    thr = thr_c[3*TW-1:2*TW];
            4'd9:    thr = thr_d;
            default: thr = '0;
        endcase
    end

    assign flip = {1'b0, random_value} < thr;

endmodule

/* rtl/core/ising_2d_metropolis_sweep_core.sv */
// Top level of the 2-D Ising Metropolis sweep core.
// The core holds a MAX_ROWS x MAX_COLS lattice of spins (1 = +1) and visits the
// rows_in_use x cols_in_use region in raster order, one site per input item;
// each item carries the random word for that site and yields exactly one result
// item (site, flipped, new spin, last-of-sweep flag) in the next cycle.
// Throughput is one item per clock while in_stall is low, with no bubbles at
// row ends: spin rows live in a RAM, while a four-row window in flops (row
// above, current row, row below and one row of lookahead) plus one registered
// RAM read of the row after that keeps every neighbour in registers. The
// current row is written back to the RAM when the sweep leaves it. Reset leaves
// every spin at +1 through per-row valid bits, so no clearing pass is needed.
// A write to rows_in_use or cols_in_use starts a refill (one write-back, five
// reads) during which input items are stalled and cfg_ready is low.
module ising_2d_metropolis_sweep_core #(
    parameter int MAX_ROWS = ising2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ising2d_pkg::DEF_MAX_COLS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ising2d_pkg::RND_W-1:0]        random_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ising2d_pkg::SITE_W-1:0]       site_row,
    output logic [ising2d_pkg::SITE_W-1:0]       site_col,
    output logic                                 flipped,
    output logic                                 new_spin,
    output logic                                 last_of_sweep,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ising2d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ising2d_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS);      // row index
    localparam int CW  = $clog2(MAX_COLS);      // column index
    localparam int RCW = $clog2(MAX_ROWS + 1);  // row count
    localparam int CCW = $clog2(MAX_COLS + 1);  // column count
    localparam int RX  = RCW + 2;               // row arithmetic
    localparam int CX  = CCW + 1;               // column arithmetic
    localparam int SW  = ising2d_pkg::SIZE_W;
    localparam int RSW = ((RCW > SW) ? RCW : SW) + 1;
    localparam int CSW = ((CCW > SW) ? CCW : SW) + 1;
    localparam int OW  = ising2d_pkg::SITE_W;
    localparam int TW  = ising2d_pkg::THR_W;
    localparam int PW  = ising2d_pkg::THR_PACK_W;

    // ---------------------------------------------------------------- config
    logic          boundary_reg;
    logic [SW-1:0] rows_cfg_reg;
    logic [SW-1:0] cols_cfg_reg;
    logic [PW-1:0] thr_a_reg;
    logic [PW-1:0] thr_b_reg;
    logic [PW-1:0] thr_c_reg;
    logic [TW-1:0] thr_d_reg;

    logic cfg_acc;
    logic size_write;

    ising2d_pkg::ctl_state_t state_reg, state_next;

    assign cfg_ready  = (state_reg == ising2d_pkg::ST_RUN);
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign size_write = cfg_acc &&
                        ((ising2d_pkg::cfg_idx_t'(cfg_index) == ising2d_pkg::CFG_ROWS) ||
                         (ising2d_pkg::cfg_idx_t'(cfg_index) == ising2d_pkg::CFG_COLS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg <= 1'b0;
            rows_cfg_reg <= ising2d_pkg::SIZE_RST;
            cols_cfg_reg <= ising2d_pkg::SIZE_RST;
            thr_a_reg    <= '0;
            thr_b_reg    <= '0;
            thr_c_reg    <= '0;
            thr_d_reg    <= '0;
        end
        else if (cfg_acc)
        begin
            case (ising2d_pkg::cfg_idx_t'(cfg_index))
                ising2d_pkg::CFG_BOUNDARY: boundary_reg <= cfg_data[0];
                ising2d_pkg::CFG_ROWS:     rows_cfg_reg <= cfg_data[SW-1:0];
                ising2d_pkg::CFG_COLS:     cols_cfg_reg <= cfg_data[SW-1:0];
                ising2d_pkg::CFG_THR_A:    thr_a_reg    <= cfg_data[PW-1:0];
                ising2d_pkg::CFG_THR_B:    thr_b_reg    <= cfg_data[PW-1:0];
                ising2d_pkg::CFG_THR_C:    thr_c_reg    <= cfg_data[PW-1:0];
                ising2d_pkg::CFG_THR_D:    thr_d_reg    <= cfg_data[TW-1:0];
                default:                   ;
            endcase
        end
    end

    // effective region size: zero acts as one, oversize clamps to the maximum
    logic [RSW-1:0] rows_wide;
    logic [CSW-1:0] cols_wide;
    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;

    always_comb
    begin
        rows_wide = RSW'(rows_cfg_reg);
        cols_wide = CSW'(cols_cfg_reg);
        if (rows_wide == '0)
            rows_eff = RCW'(1);
        else if (rows_wide > RSW'(MAX_ROWS))
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = rows_wide[RCW-1:0];
        if (cols_wide == '0)
            cols_eff = CCW'(1);
        else if (cols_wide > CSW'(MAX_COLS))
            cols_eff = CCW'(MAX_COLS);
        else
            cols_eff = cols_wide[CCW-1:0];
    end

    logic rows_is1;
    logic rows_is2;
    logic rows_is3;
    logic rows_is4;

    assign rows_is1 = (rows_eff == RCW'(1));
    assign rows_is2 = (rows_eff == RCW'(2));
    assign rows_is3 = (rows_eff == RCW'(3));
    assign rows_is4 = (rows_eff == RCW'(4));

    // ---------------------------------------------------------------- state
    logic [RW-1:0]         row_cursor_reg, row_cursor_next;
    logic [CW-1:0]         col_cursor_reg, col_cursor_next;
    logic [MAX_COLS-1:0]   up_reg, up_next;     // row r-1, already swept
    logic [MAX_COLS-1:0]   cur_reg, cur_next;   // row r, updated in place
    logic [MAX_COLS-1:0]   dn_reg, dn_next;     // row r+1
    logic [MAX_COLS-1:0]   dn2_reg, dn2_next;   // row r+2 lookahead
    logic [MAX_ROWS-1:0]   vld_reg, vld_next;   // RAM row written since reset
    logic                  rd_vld_reg;
    logic [RW-1:0]         ptr_reg, ptr_next;   // refill read pointer
    logic [ising2d_pkg::LOAD_CNT_W-1:0] load_cnt_reg, load_cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OW-1:0]         site_row_reg, site_row_next;
    logic [OW-1:0]         site_col_reg, site_col_next;
    logic                  flipped_reg, flipped_next;
    logic                  new_spin_reg, new_spin_next;
    logic                  last_reg, last_next;

    // ---------------------------------------------------------------- RAM
    logic                ram_we;
    logic [RW-1:0]       ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [RW-1:0]       ram_raddr;
    logic [MAX_COLS-1:0] ram_q;
    logic [MAX_COLS-1:0] rd_row;

    ising2d_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // a row never written still holds its reset value, all spins up
    assign rd_row = rd_vld_reg ? ram_q : {MAX_COLS{1'b1}};

    // ---------------------------------------------------------------- site
    logic          in_acc;
    logic [RX-1:0] r_ext;
    logic [CX-1:0] c_ext;
    logic          row_end;
    logic          col_end;
    logic          periodic;
    logic [CW-1:0] col_lf;
    logic [CW-1:0] col_rt;
    logic [MAX_COLS-1:0] up_row;
    logic [MAX_COLS-1:0] dn_row;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] cur_upd;
    ising2d_pkg::nbr_t nbr;
    logic          flip;

    assign in_stall = (state_reg != ising2d_pkg::ST_RUN) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    assign r_ext    = RX'(row_cursor_reg);
    assign c_ext    = CX'(col_cursor_reg);
    assign row_end  = (r_ext + RX'(1) == RX'(rows_eff));
    assign col_end  = (c_ext + CX'(1) == CX'(cols_eff));
    assign periodic = !boundary_reg;

    // periodic column wrap; for one column both sides are the site itself
    assign col_lf = (col_cursor_reg == '0) ? CW'(cols_eff - CCW'(1))
                                           : col_cursor_reg - CW'(1);
    assign col_rt = col_end ? '0 : col_cursor_reg + CW'(1);

    // a single row is its own vertical neighbour
    assign up_row = rows_is1 ? cur_reg : up_reg;
    assign dn_row = rows_is1 ? cur_reg : dn_reg;

    always_comb
    begin
        nbr.spin  = cur_reg[col_cursor_reg];
        nbr.up    = up_row[col_cursor_reg];
        nbr.dn    = dn_row[col_cursor_reg];
        nbr.lf    = cur_reg[col_lf];
        nbr.rt    = cur_reg[col_rt];
        nbr.up_en = periodic || (row_cursor_reg != '0);
        nbr.dn_en = periodic || !row_end;
        nbr.lf_en = periodic || (col_cursor_reg != '0);
        nbr.rt_en = periodic || !col_end;
    end

    ising2d_site_eval u_eval (
        .nbr          (nbr),
        .random_value (random_value),
        .thr_a        (thr_a_reg),
        .thr_b        (thr_b_reg),
        .thr_c        (thr_c_reg),
        .thr_d        (thr_d_reg),
        .flip         (flip)
    );

    assign col_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_cursor_reg;
    assign cur_upd  = flip ? (cur_reg ^ col_mask) : cur_reg;

    // ---------------------------------------------------------------- refill
    logic          cursor_out;
    logic [RW-1:0] row_norm;
    logic [CW-1:0] col_norm;
    logic [RW-1:0] ptr_up;
    logic [RW-1:0] ptr_inc;

    assign cursor_out = (r_ext >= RX'(rows_eff)) || (c_ext >= CX'(cols_eff));
    assign row_norm   = cursor_out ? '0 : row_cursor_reg;
    assign col_norm   = cursor_out ? '0 : col_cursor_reg;
    assign ptr_up     = (row_norm == '0) ? RW'(rows_eff - RCW'(1)) : row_norm - RW'(1);
    assign ptr_inc    = (RX'(ptr_reg) + RX'(1) == RX'(rows_eff)) ? '0 : ptr_reg + RW'(1);

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        ptr_next      = ptr_reg;
        case (state_reg)
            ising2d_pkg::ST_RUN:
            begin
                if (size_write)
                    state_next = ising2d_pkg::ST_FLUSH;
            end
            ising2d_pkg::ST_FLUSH:
            begin
                state_next    = ising2d_pkg::ST_LOAD;
                load_cnt_next = '0;
                ptr_next      = ptr_up;
            end
            ising2d_pkg::ST_LOAD:
            begin
                ptr_next = ptr_inc;
                if (load_cnt_reg == ising2d_pkg::LOAD_LAST)
                    state_next = ising2d_pkg::ST_RUN;
                else
                    load_cnt_next = load_cnt_reg + 3'd1;
            end
            default:
            begin
                state_next = ising2d_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ising2d_pkg::ST_RUN;
            load_cnt_reg <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            ptr_reg      <= ptr_next;
        end
    end

    // ---------------------------------------------------------------- window
    // Every window entry holds the latest copy of its row, except copies that
    // alias the current row on tiny lattices; those are taken from cur_upd.
    always_comb
    begin
        row_cursor_next = row_cursor_reg;
        col_cursor_next = col_cursor_reg;
        up_next         = up_reg;
        cur_next        = cur_reg;
        dn_next         = dn_reg;
        dn2_next        = dn2_reg;
        ram_we          = 1'b0;
        ram_waddr       = row_cursor_reg;
        ram_wdata       = cur_upd;

        case (state_reg)
            ising2d_pkg::ST_RUN:
            begin
                if (in_acc)
                begin
                    if (col_end)
                    begin
                        col_cursor_next = '0;
                        row_cursor_next = row_end ? '0 : row_cursor_reg + RW'(1);
                        ram_we          = 1'b1;
                        up_next         = cur_upd;
                        cur_next        = rows_is1 ? cur_upd : dn_reg;
                        dn_next         = (rows_is1 || rows_is2) ? cur_upd : dn2_reg;
                        if (rows_is1 || rows_is3)
                            dn2_next = cur_upd;
                        else if (rows_is2)
                            dn2_next = dn_reg;
                        else if (rows_is4)
                            dn2_next = up_reg;
                        else
                            dn2_next = rd_row;
                    end
                    else
                    begin
                        col_cursor_next = col_cursor_reg + CW'(1);
                        cur_next        = cur_upd;
                    end
                end
            end
            ising2d_pkg::ST_FLUSH:
            begin
                ram_we          = 1'b1;
                ram_wdata       = cur_reg;
                row_cursor_next = row_norm;
                col_cursor_next = col_norm;
            end
            ising2d_pkg::ST_LOAD:
            begin
                case (load_cnt_reg)
                    3'd1:    up_next  = rd_row;
                    3'd2:    cur_next = rd_row;
                    3'd3:    dn_next  = rd_row;
                    3'd4:    dn2_next = rd_row;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // lookahead read: row three below the cursor as it stands after this edge
    logic [RX-1:0] row3_sum;
    logic [RX-1:0] row3_wrap;
    logic [RW-1:0] row3;

    always_comb
    begin
        row3_sum  = RX'(row_cursor_next) + RX'(3);
        row3_wrap = (row3_sum >= RX'(rows_eff)) ? row3_sum - RX'(rows_eff) : row3_sum;
        // only used for five rows or more; kept in range otherwise
        row3      = (row3_wrap >= RX'(rows_eff)) ? '0 : row3_wrap[RW-1:0];
    end

    assign ram_raddr = (state_reg == ising2d_pkg::ST_RUN) ? row3 : ptr_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (ram_we)
            vld_next[ram_waddr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cursor_reg <= '0;
            col_cursor_reg <= '0;
            up_reg         <= '1;
            cur_reg        <= '1;
            dn_reg         <= '1;
            dn2_reg        <= '1;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            row_cursor_reg <= row_cursor_next;
            col_cursor_reg <= col_cursor_next;
            up_reg         <= up_next;
            cur_reg        <= cur_next;
            dn_reg         <= dn_next;
            dn2_reg        <= dn2_next;
            vld_reg        <= vld_next;
            rd_vld_reg     <= vld_reg[ram_raddr];
        end
    end

    // ---------------------------------------------------------------- output
    logic [RW+OW-1:0] row_wide;
    logic [CW+OW-1:0] col_wide;

    assign row_wide = {{OW{1'b0}}, row_cursor_reg};
    assign col_wide = {{OW{1'b0}}, col_cursor_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        site_row_next  = site_row_reg;
        site_col_next  = site_col_reg;
        flipped_next   = flipped_reg;
        new_spin_next  = new_spin_reg;
        last_next      = last_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            site_row_next  = row_wide[OW-1:0];
            site_col_next  = col_wide[OW-1:0];
            flipped_next   = flip;
            new_spin_next  = nbr.spin ^ flip;
            last_next      = row_end && col_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        site_row_reg <= site_row_next;
        site_col_reg <= site_col_next;
        flipped_reg  <= flipped_next;
        new_spin_reg <= new_spin_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign site_row      = site_row_reg;
    assign site_col      = site_col_reg;
    assign flipped       = flipped_reg;
    assign new_spin      = new_spin_reg;
    assign last_of_sweep = last_reg;

    // ---------------------------------------------------------------- checks
    a_size_write_refills: assert property (@(posedge clk) disable iff (!rst_n)
        size_write |=> state_reg == ising2d_pkg::ST_FLUSH)
        else $error("size write did not start a refill");

    a_flush_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ising2d_pkg::ST_FLUSH |=>
            (state_reg == ising2d_pkg::ST_LOAD) && (load_cnt_reg == '0))
        else $error("refill did not start its read sequence");

    a_cursor_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ising2d_pkg::ST_RUN |->
            (r_ext < RX'(rows_eff)) && (c_ext < CX'(cols_eff)))
        else $error("cursor outside region while sweeping");

    a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && row_end && col_end |=>
            (row_cursor_reg == '0) && (col_cursor_reg == '0))
        else $error("sweep did not restart at the origin");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the 2-D Ising Metropolis sweep core.
module tb;
    import ising2d_pkg::*;

    localparam int MAX_R = DEF_MAX_ROWS;
    localparam int MAX_C = DEF_MAX_COLS;

    // Watchdog, in clock cycles. The slowest legal run (every item behind a long
    // sender gap and a long result stall) stays well below this.
    localparam int LIMIT_CYCLES = 1_500_000;

    // Random items to send after the directed part.
    localparam int RAND_ITEMS = 1750;

    localparam logic [THR_W-1:0]      THR_ALWAYS = 17'h10000;
    localparam logic [THR_PACK_W-1:0] THR_ALL1   = {THR_PACK_W{1'b1}};

    // One result item: the site visited and what happened to it.
    typedef struct packed {
        logic [SITE_W-1:0] row;
        logic [SITE_W-1:0] col;
        logic              flip;
        logic              spin;
        logic              last;
    } site_rec_t;

    localparam site_rec_t NO_SITE = '0;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    // Directed stimulus row: a register write or an item. Item rows with 'typed'
    // set carry an expectation written by hand; all others use the predictor.
    typedef struct packed {
        row_kind_t              kind;
        cfg_idx_t               reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [RND_W-1:0]       rnd;
        logic                   typed;
        site_rec_t              want;
    } stim_row_t;

    localparam int DIR_ROWS = 36;

    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // right after reset: every spin up, all thresholds zero, so no flips
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h0000, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b1, '{6'd0, 6'd1, 1'b0, 1'b1, 1'b0}},
        // every entry saturated (17'h1FFFF), entry 9 at exactly 65536
        '{ROW_CFG,  CFG_THR_A,    THR_ALL1, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_THR_B,    THR_ALL1, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_THR_C,    THR_ALL1, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_THR_D,    51'(THR_ALWAYS), 16'h0, 1'b0, NO_SITE},
        // 1x1 periodic lattice: site is its own neighbour four times; the cursor
        // at (0,2) is outside the new region, so the sweep restarts at (0,0)
        '{ROW_CFG,  CFG_ROWS,     51'd1, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_COLS,     51'd1, 16'h0, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b0, 1'b1}},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b1, 1'b1}},
        // zero rows acts as one, 127 columns as the maximum
        '{ROW_CFG,  CFG_ROWS,     51'd0, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_COLS,     51'd127, 16'h0, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h8000, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h0000, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b0, NO_SITE},
        // free edges on 2x2: every site is a corner with two neighbours
        '{ROW_CFG,  CFG_BOUNDARY, 51'd1, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_ROWS,     51'd2, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_COLS,     51'd2, 16'h0, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h0000, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h5A5A, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hA5A5, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b0, NO_SITE},
        // down-spin entries: 6..8 never, 9 just one short of always
        '{ROW_CFG,  CFG_THR_C,    51'd0, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_THR_D,    51'h0FFFF, 16'h0, 1'b0, NO_SITE},
        // periodic 2x2: the same neighbour counts twice
        '{ROW_CFG,  CFG_BOUNDARY, 51'd0, 16'h0, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFE, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h0001, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h7FFF, 1'b0, NO_SITE},
        // tall and narrow region
        '{ROW_CFG,  CFG_ROWS,     51'd64, 16'h0, 1'b0, NO_SITE},
        '{ROW_CFG,  CFG_COLS,     51'd3, 16'h0, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h0000, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'hFFFF, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h1234, 1'b0, NO_SITE},
        '{ROW_ITEM, CFG_BOUNDARY, 51'd0, 16'h8001, 1'b0, NO_SITE}
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT pins. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [RND_W-1:0]      random_value = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SITE_W-1:0]     site_row;
    logic [SITE_W-1:0]     site_col;
    logic                  flipped;
    logic                  new_spin;
    logic                  last_of_sweep;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    ising_2d_metropolis_sweep_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .random_value  (random_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .site_row      (site_row),
        .site_col      (site_col),
        .flipped       (flipped),
        .new_spin      (new_spin),
        .last_of_sweep (last_of_sweep),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the lattice, sweep cursor and
    // register file, kept in step with every accepted item and write.
    // ------------------------------------------------------------------
    logic [MAX_C-1:0]      lattice [MAX_R];
    int unsigned           cur_row;
    int unsigned           cur_col;
    logic                  free_edges;
    logic [SIZE_W-1:0]     rows_reg;
    logic [SIZE_W-1:0]     cols_reg;
    logic [THR_PACK_W-1:0] thr_a_reg;
    logic [THR_PACK_W-1:0] thr_b_reg;
    logic [THR_PACK_W-1:0] thr_c_reg;
    logic [THR_W-1:0]      thr_d_reg;

    site_rec_t   expected_sites [$];
    site_rec_t   oldest_site;
    int unsigned err_count = 0;
    int unsigned result_count = 0;

    // Register sizes: zero acts as one, anything past the array as the maximum.
    function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int spin_val(int unsigned r, int unsigned c);
        return lattice[r][c] ? 1 : -1;
    endfunction

    // Entries 0..8 are packed three to a register, entry 9 stands alone.
    function automatic logic [THR_W-1:0] flip_threshold(int unsigned k);
        logic [THR_PACK_W-1:0] word;
        if (k >= 9)
            return thr_d_reg;
        word = (k < 3) ? thr_a_reg : (k < 6) ? thr_b_reg : thr_c_reg;
        return word[THR_W * (k % 3) +: THR_W];
    endfunction

    // One Metropolis update at the cursor; advances the raster sweep.
    function automatic site_rec_t metropolis_step(logic [RND_W-1:0] rnd);
        int unsigned nr;
        int unsigned nc;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        int          s;
        int          nsum;
        site_rec_t   res;
        nr = eff_size(rows_reg, MAX_R);
        nc = eff_size(cols_reg, MAX_C);
        if (cur_row >= nr || cur_col >= nc)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        s = spin_val(r, c);
        nsum = 0;
        if (!free_edges)
        begin
            nsum += spin_val((r + nr - 1) % nr, c);
            nsum += spin_val((r + 1) % nr, c);
            nsum += spin_val(r, (c + nc - 1) % nc);
            nsum += spin_val(r, (c + 1) % nc);
        end
        else
        begin
            if (r > 0)
                nsum += spin_val(r - 1, c);
            if (r + 1 < nr)
                nsum += spin_val(r + 1, c);
            if (c > 0)
                nsum += spin_val(r, c - 1);
            if (c + 1 < nc)
                nsum += spin_val(r, c + 1);
        end
        // numerator is 0..18, so integer division is the floor
        k = (nsum - 5 * s + 9) / 2;
        res.flip = ({1'b0, rnd} < flip_threshold(k));
        if (res.flip)
            lattice[r][c] = ~lattice[r][c];
        res.row  = SITE_W'(r);
        res.col  = SITE_W'(c);
        res.spin = lattice[r][c];
        res.last = (r + 1 == nr) && (c + 1 == nc);
        if (c + 1 < nc)
            cur_col = c + 1;
        else
        begin
            cur_col = 0;
            cur_row = (r + 1 < nr) ? r + 1 : 0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RND_W-1:0] rand_word();
        int unsigned p;
        p = $urandom_range(0, 15);
        if (p == 0)
            return '0;
        if (p == 1)
            return '1;
        return RND_W'($urandom_range(0, 65535));
    endfunction

    // Thresholds: never, exactly always, saturated, any 17-bit value, or mostly
    // a value in the useful 0..65536 range so that flips are mixed.
    function automatic logic [THR_W-1:0] rand_thr();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return '0;
        if (p == 1)
            return THR_ALWAYS;
        if (p == 2)
            return '1;
        if (p == 3)
            return THR_W'($urandom);
        return THR_W'($urandom_range(0, 65536));
    endfunction

    // Region sizes, with zero and oversize values that the core must clamp.
    function automatic logic [SIZE_W-1:0] rand_size();
        int unsigned p;
        p = $urandom_range(0, 15);
        case (p)
            0:       return '0;
            1:       return 7'd64;
            2:       return SIZE_W'($urandom_range(65, 127));
            3:       return 7'd1;
            4:       return 7'd2;
            5:       return 7'd63;
            default: return SIZE_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_wide();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t result %0d: %s", $time, result_count, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [SITE_W-1:0] got, logic [SITE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Outputs are registered and out_stall is driven by NBA, so reading them in
    // the active region of the edge gives the values the core saw at that edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sites.size() == 0)
                report_mismatch($sformatf("unexpected result at (%0d,%0d)",
                                          site_row, site_col));
            else
            begin
                oldest_site = expected_sites.pop_front();
                check_field("site_row", site_row, oldest_site.row);
                check_field("site_col", site_col, oldest_site.col);
                check_field("flipped", flipped, oldest_site.flip);
                check_field("new_spin", new_spin, oldest_site.spin);
                check_field("last_of_sweep", last_of_sweep, oldest_site.last);
            end
            result_count++;
        end
    end

    // Receiver back-pressure: random stall runs, mostly short, a few long, with
    // occasional long stretches where every result is taken at once.
    initial
    begin
        int unsigned hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold != 0)
                hold--;
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                hold = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 100)
                                                   : $urandom_range(0, 5);
            end
            else
            begin
                hold = idle_len();
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    hold--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item, optionally after an idle gap. in_valid stays high between
    // back-to-back items, so it never gets two NBAs in one step.
    task automatic send_item(logic [RND_W-1:0] rnd, bit typed, site_rec_t want,
                             bit no_gap);
        int unsigned gap;
        site_rec_t   pred;
        gap = no_gap ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        random_value <= rnd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: advance the predictor
        pred = metropolis_step(rnd);
        expected_sites.push_back(typed ? want : pred);
    endtask

    // Drop valid and wait for every outstanding result. Each item yields exactly
    // one result, so an empty queue means the core is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_sites.size() != 0)
            @(posedge clk);
    endtask

    // Register write; the predictor copy applies the same field masks.
    // Size writes make the core refill its row window with cfg_ready low.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BOUNDARY: free_edges = data[0];
            CFG_ROWS:     rows_reg   = data[SIZE_W-1:0];
            CFG_COLS:     cols_reg   = data[SIZE_W-1:0];
            CFG_THR_A:    thr_a_reg  = data;
            CFG_THR_B:    thr_b_reg  = data;
            CFG_THR_C:    thr_c_reg  = data;
            CFG_THR_D:    thr_d_reg  = data[THR_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned           rand_items;
        int unsigned           phase;
        int unsigned           n_items;
        int unsigned           area;
        logic [SIZE_W-1:0]     rsz;
        logic [SIZE_W-1:0]     csz;
        logic [CFG_DATA_W-1:0] wide;
        bit                    burst;

        // predictor reset state: all spins up, full 64x64 region, periodic
        for (int r = 0; r < MAX_R; r++)
            lattice[r] = '1;
        cur_row    = 0;
        cur_col    = 0;
        free_edges = 1'b0;
        rows_reg   = SIZE_RST;
        cols_reg   = SIZE_RST;
        thr_a_reg  = '0;
        thr_b_reg  = '0;
        thr_c_reg  = '0;
        thr_d_reg  = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Writes only happen with nothing in flight.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].wdata);
            end
            else
                send_item(DIR_TAB[i].rnd, DIR_TAB[i].typed, DIR_TAB[i].want, 1'b0);
        end

        // Random phases: reprogram a random subset of registers, then run a
        // stretch of items long enough to finish a sweep or two on small regions.
        // The first two phases force a full-height column and a full-width row so
        // that the extreme site indices come up.
        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS)
        begin
            drain_results();
            rsz = rand_size();
            csz = rand_size();
            if (phase == 0)
            begin
                rsz = 7'd64;
                csz = 7'd1;
            end
            else if (phase == 1)
            begin
                rsz = 7'd1;
                csz = 7'd64;
            end
            // stray upper bits of cfg_data must be ignored
            wide = rand_wide();
            if ($urandom_range(0, 1))
                write_reg(CFG_BOUNDARY, {wide[CFG_DATA_W-1:1], 1'($urandom)});
            if (phase < 2 || $urandom_range(0, 3) != 0)
                write_reg(CFG_ROWS, {wide[CFG_DATA_W-1:SIZE_W], rsz});
            if (phase < 2 || $urandom_range(0, 3) != 0)
                write_reg(CFG_COLS, {wide[CFG_DATA_W-1:SIZE_W], csz});
            if ($urandom_range(0, 1))
                write_reg(CFG_THR_A, {rand_thr(), rand_thr(), rand_thr()});
            if ($urandom_range(0, 1))
                write_reg(CFG_THR_B, {rand_thr(), rand_thr(), rand_thr()});
            if ($urandom_range(0, 1))
                write_reg(CFG_THR_C, {rand_thr(), rand_thr(), rand_thr()});
            if ($urandom_range(0, 1))
                write_reg(CFG_THR_D, {wide[CFG_DATA_W-1:THR_W], rand_thr()});

            area = eff_size(rows_reg, MAX_R) * eff_size(cols_reg, MAX_C);
            if (area <= 64)
                n_items = area * $urandom_range(2, 4) + $urandom_range(0, 3);
            else if (area <= 128)
                n_items = area + $urandom_range(0, 20);
            else
                n_items = $urandom_range(40, 150);
            // last phase stops at the item budget
            if (n_items > RAND_ITEMS - rand_items)
                n_items = RAND_ITEMS - rand_items;

            // some phases run with no sender gaps at all
            burst = ($urandom_range(0, 3) == 0);
            repeat (n_items)
                send_item(rand_word(), 1'b0, NO_SITE, burst);
            rand_items += n_items;
            phase++;
        end

        drain_results();
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ising2d_pkg.sv
rtl/core/ising2d_ram.sv
rtl/core/ising2d_site_eval.sv
rtl/core/ising_2d_metropolis_sweep_core.sv
verif/tb.sv
